// ===== rtl/hvs_pkg.sv =====
// hvs_pkg: shared widths, constants and item types for the hsv value scaler
// used by every module under rtl/; depends on nothing
package hvs_pkg;

  localparam int CHAN_W      = 8;
  localparam int PIX_W       = 3 * CHAN_W;
  localparam int GAIN_W      = 10;
  localparam int PROD_W      = CHAN_W + GAIN_W;
  localparam int NUM_W       = 2 * CHAN_W;
  localparam int DIV_LAT     = CHAN_W;
  localparam int RECIP_SHIFT = 24;
  localparam int RECIP_W     = 18;
  localparam int PCT_BASE    = 100;
  localparam int PCT_RECIP   = (1 << RECIP_SHIFT) / PCT_BASE;
  localparam int QE_W        = PROD_W + RECIP_W - RECIP_SHIFT;
  localparam int QUEUE_DEPTH = 2;

  localparam logic [GAIN_W-1:0] GAIN_RESET = GAIN_W'(155);
  localparam logic [CHAN_W-1:0] CHAN_MAX   = {CHAN_W{1'b1}};

  typedef struct packed {
    logic [PIX_W-1:0]  rgb;
    logic [CHAN_W-1:0] vmax;
    logic [CHAN_W-1:0] vmin;
    logic [CHAN_W-1:0] span;
    logic [CHAN_W-1:0] hi;
    logic              pass;
  } hvs_item_t;

  typedef struct packed {
    hvs_item_t         item;
    logic [CHAN_W-1:0] lo;
  } hvs_work_t;

endpackage

// ===== rtl/hsv_value_scale_pixel.sv =====
// hsv_value_scale_pixel: scales the hsv value of rgb pixels by a percentage
// top level; depends on hvs_pkg, hvs_front, hvs_queue, hvs_back, hvs_div
//
// Takes one 24-bit rgb pixel (red 23:16, green 15:8, blue 7:0) per clock and
// returns it with its value scaled by cfg gain (percent, reset 155) while hue
// and saturation are kept; black pixels and pixels whose maximum does not
// change pass through, grey pixels take the new maximum on every channel.
// Throughput is one pixel per clock when the output does not stall; a pixel
// goes through max/min and divide-by-100 in the front, the queue, and the
// back end, built on two 8-stage pipelined dividers in series. Gain must be
// written only while no pixel is in flight; the block itself does not enforce it.
module hsv_value_scale_pixel #(
  parameter int QUEUE_DEPTH = hvs_pkg::QUEUE_DEPTH
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       cfg_wr_en,
  input  logic [hvs_pkg::GAIN_W-1:0] cfg_wr_data,  // gain_percent
  input  logic                       in_tvalid,
  output logic                       in_tready,
  input  logic [hvs_pkg::PIX_W-1:0]  in_tdata,     // pixel_rgb
  output logic                       out_tvalid,
  input  logic                       out_tready,
  output logic [hvs_pkg::PIX_W-1:0]  out_tdata     // scaled_rgb
);

  logic [hvs_pkg::GAIN_W-1:0] gain_r;
  logic                       f_valid, f_ready, q_valid, q_ready;
  hvs_pkg::hvs_item_t         f_item, q_item;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gain_r <= hvs_pkg::GAIN_RESET;
    end else if (cfg_wr_en) begin
      gain_r <= cfg_wr_data;
    end
  end

  hvs_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .gain      (gain_r),
    .in_valid  (in_tvalid),
    .in_ready  (in_tready),
    .in_rgb    (in_tdata),
    .out_valid (f_valid),
    .out_ready (f_ready),
    .out_item  (f_item)
  );

  hvs_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (f_valid),
    .in_ready  (f_ready),
    .in_item   (f_item),
    .out_valid (q_valid),
    .out_ready (q_ready),
    .out_item  (q_item)
  );

  hvs_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (q_valid),
    .in_ready  (q_ready),
    .in_item   (q_item),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_rgb   (out_tdata)
  );

endmodule

// ===== rtl/hvs_div.sv =====
// hvs_div: pipelined restoring divider, 16-bit numerator by 8-bit divisor,
// 8-bit quotient, one quotient bit per stage; depends on hvs_pkg
module hvs_div (
  input  logic                       clk,
  input  logic                       en,
  input  logic [hvs_pkg::NUM_W-1:0]  num,
  input  logic [hvs_pkg::CHAN_W-1:0] den,
  output logic [hvs_pkg::CHAN_W-1:0] quo
);

  localparam int N = hvs_pkg::DIV_LAT;
  localparam int W = hvs_pkg::CHAN_W;

  logic [W-1:0] rem_r [N];
  logic [W-1:0] low_r [N];
  logic [W-1:0] den_r [N];
  logic [W-1:0] quo_r [N];
  logic [W-1:0] rem_nxt [N];
  logic [W-1:0] low_nxt [N];
  logic [W-1:0] den_nxt [N];
  logic [W-1:0] quo_nxt [N];

  always_comb begin
    logic [W-1:0] rem_in, low_in, den_in, quo_in;
    logic [W:0]   trial;
    logic         ge;
    for (int i = 0; i < N; i++) begin
      if (i == 0) begin
        rem_in = num[2*W-1:W];
        low_in = num[W-1:0];
        den_in = den;
        quo_in = '0;
      end else begin
        rem_in = rem_r[i-1];
        low_in = low_r[i-1];
        den_in = den_r[i-1];
        quo_in = quo_r[i-1];
      end
      trial      = {rem_in, low_in[W-1]};
      ge         = trial >= {1'b0, den_in};
      rem_nxt[i] = ge ? W'(trial - {1'b0, den_in}) : trial[W-1:0];
      low_nxt[i] = {low_in[W-2:0], 1'b0};
      den_nxt[i] = den_in;
      quo_nxt[i] = {quo_in[W-2:0], ge};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < N; i++) begin
        rem_r[i] <= rem_nxt[i];
        low_r[i] <= low_nxt[i];
        den_r[i] <= den_nxt[i];
        quo_r[i] <= quo_nxt[i];
      end
    end
  end

  assign quo = quo_r[N-1];

endmodule

// ===== rtl/hvs_front.sv =====
// hvs_front: finds channel max/min, computes the new maximum and flags
// pass-through pixels; depends on hvs_pkg
module hvs_front (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic [hvs_pkg::GAIN_W-1:0] gain,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic [hvs_pkg::PIX_W-1:0]  in_rgb,
  output logic                       out_valid,
  input  logic                       out_ready,
  output hvs_pkg::hvs_item_t         out_item
);

  localparam int W  = hvs_pkg::CHAN_W;
  localparam int PW = hvs_pkg::PROD_W;
  localparam int QW = hvs_pkg::QE_W;
  localparam int FW = hvs_pkg::PROD_W + hvs_pkg::RECIP_W;

  logic          en;
  logic [W-1:0]  r, g, b, mx, mn, mrg, mng;
  logic [PW-1:0] prod;
  logic [FW-1:0] qe_full;

  logic              v1_r, v2_r;
  logic [W*3-1:0]    rgb1_r, rgb2_r;
  logic [W-1:0]      vmax1_r, vmin1_r, vmax2_r, vmin2_r;
  logic [PW-1:0]     prod1_r, prod2_r;
  logic [QW-1:0]     qe2_r;

  logic [PW-1:0] qmul, rem;
  logic [QW-1:0] hi_full;
  logic [W-1:0]  hi;

  assign en       = !v2_r || out_ready;
  assign in_ready = en;

  assign r    = in_rgb[3*W-1:2*W];
  assign g    = in_rgb[2*W-1:W];
  assign b    = in_rgb[W-1:0];
  assign mrg  = (r > g) ? r : g;
  assign mx   = (mrg > b) ? mrg : b;
  assign mng  = (r < g) ? r : g;
  assign mn   = (mng < b) ? mng : b;
  assign prod = PW'(mx) * PW'(gain);

  // divide by 100 via reciprocal, off by at most one low
  assign qe_full = FW'(prod1_r) * FW'(hvs_pkg::PCT_RECIP);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
    end else if (en) begin
      v1_r <= in_valid;
      v2_r <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rgb1_r  <= in_rgb;
      vmax1_r <= mx;
      vmin1_r <= mn;
      prod1_r <= prod;
      rgb2_r  <= rgb1_r;
      vmax2_r <= vmax1_r;
      vmin2_r <= vmin1_r;
      prod2_r <= prod1_r;
      qe2_r   <= qe_full[FW-1:hvs_pkg::RECIP_SHIFT];
    end
  end

  assign qmul    = PW'(qe2_r) * PW'(hvs_pkg::PCT_BASE);
  assign rem     = prod2_r - qmul;
  assign hi_full = qe2_r + QW'(rem >= PW'(hvs_pkg::PCT_BASE));
  assign hi      = (hi_full > QW'(hvs_pkg::CHAN_MAX)) ? hvs_pkg::CHAN_MAX : hi_full[W-1:0];

  always_comb begin
    out_item.rgb  = rgb2_r;
    out_item.vmax = vmax2_r;
    out_item.vmin = vmin2_r;
    out_item.span = vmax2_r - vmin2_r;
    out_item.hi   = hi;
    out_item.pass = (vmax2_r == '0) || (hi == vmax2_r);
  end

  assign out_valid = v2_r;

endmodule

// ===== rtl/hvs_queue.sv =====
// hvs_queue: small registered fifo between the classify front and the
// remap back; depends on hvs_pkg
module hvs_queue #(
  parameter int DEPTH = hvs_pkg::QUEUE_DEPTH
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  hvs_pkg::hvs_item_t in_item,
  output logic               out_valid,
  input  logic               out_ready,
  output hvs_pkg::hvs_item_t out_item
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  hvs_pkg::hvs_item_t mem_r [DEPTH];
  logic [PTR_W-1:0]   wr_ptr_r, rd_ptr_r, wr_ptr_nxt, rd_ptr_nxt;
  logic [CNT_W-1:0]   cnt_r, cnt_nxt;
  logic               push, pop;

  assign in_ready  = cnt_r != CNT_W'(DEPTH);
  assign out_valid = cnt_r != '0;
  assign push      = in_valid && in_ready;
  assign pop       = out_valid && out_ready;
  assign out_item  = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= in_item;
    end
  end

endmodule

// ===== rtl/hvs_back.sv =====
// hvs_back: computes the new minimum and remaps each channel through
// pipelined dividers; depends on hvs_pkg and hvs_div
module hvs_back (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  hvs_pkg::hvs_item_t        in_item,
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic [hvs_pkg::PIX_W-1:0] out_rgb
);

  localparam int W  = hvs_pkg::CHAN_W;
  localparam int NW = hvs_pkg::NUM_W;
  localparam int L  = hvs_pkg::DIV_LAT;

  logic en;

  // stage 0: numerator for the new minimum
  logic               v0_r;
  hvs_pkg::hvs_item_t it0_r;
  logic [NW-1:0]      nlo_r;
  logic [W-1:0]       dlo_r;

  // delay alongside the minimum divider
  logic               v1_r [L];
  hvs_pkg::hvs_item_t it1_r [L];
  logic [W-1:0]       q_lo;

  // stage 2: channel numerators
  logic               v2_r;
  hvs_pkg::hvs_work_t wk2_r;
  logic [NW-1:0]      nch_r [3];
  logic [W-1:0]       dch_r;
  logic [NW-1:0]      nch [3];
  logic [W-1:0]       chan1 [3];
  hvs_pkg::hvs_item_t it1;

  // delay alongside the channel dividers
  logic               v3_r [L];
  hvs_pkg::hvs_work_t wk3_r [L];
  logic [W-1:0]       t_ch [3];
  logic [W:0]         sum_ch [3];
  logic [W-1:0]       res_ch [3];
  hvs_pkg::hvs_work_t wk3;

  logic               vo_r;
  logic [3*W-1:0]     out_rgb_r, out_rgb_nxt;

  assign en       = !vo_r || out_ready;
  assign in_ready = en;

  always_ff @(posedge clk) begin
    if (en) begin
      it0_r <= in_item;
      nlo_r <= NW'(in_item.span) * NW'(in_item.hi) + NW'(in_item.vmax >> 1);
      dlo_r <= (in_item.vmax == '0) ? W'(1) : in_item.vmax;
    end
  end

  hvs_div u_div_lo (
    .clk (clk),
    .en  (en),
    .num (nlo_r),
    .den (dlo_r),
    .quo (q_lo)
  );

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < L; i++) begin
        it1_r[i] <= (i == 0) ? it0_r : it1_r[(i == 0) ? 0 : i-1];
      end
    end
  end

  assign it1 = it1_r[L-1];
  assign chan1[0] = it1.rgb[3*W-1:2*W];
  assign chan1[1] = it1.rgb[2*W-1:W];
  assign chan1[2] = it1.rgb[W-1:0];

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      nch[k] = NW'(chan1[k] - it1.vmin) * NW'(q_lo) + NW'(it1.span >> 1);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      wk2_r.item <= it1;
      wk2_r.lo   <= it1.hi - q_lo;
      for (int k = 0; k < 3; k++) begin
        nch_r[k] <= nch[k];
      end
      dch_r <= (it1.span == '0) ? W'(1) : it1.span;
    end
  end

  for (genvar k = 0; k < 3; k++) begin : g_ch
    hvs_div u_div_ch (
      .clk (clk),
      .en  (en),
      .num (nch_r[k]),
      .den (dch_r),
      .quo (t_ch[k])
    );
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < L; i++) begin
        wk3_r[i] <= (i == 0) ? wk2_r : wk3_r[(i == 0) ? 0 : i-1];
      end
    end
  end

  assign wk3 = wk3_r[L-1];

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      sum_ch[k] = {1'b0, wk3.lo} + {1'b0, t_ch[k]};
      if (wk3.item.span == '0) begin
        res_ch[k] = wk3.item.hi;
      end else if (sum_ch[k] > {1'b0, hvs_pkg::CHAN_MAX}) begin
        res_ch[k] = hvs_pkg::CHAN_MAX;
      end else begin
        res_ch[k] = sum_ch[k][W-1:0];
      end
    end
    out_rgb_nxt = wk3.item.pass ? wk3.item.rgb : {res_ch[0], res_ch[1], res_ch[2]};
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_rgb_r <= out_rgb_nxt;
    end
  end

  // valid bits of the whole pipeline
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v0_r <= 1'b0;
      v2_r <= 1'b0;
      vo_r <= 1'b0;
      for (int i = 0; i < L; i++) begin
        v1_r[i] <= 1'b0;
        v3_r[i] <= 1'b0;
      end
    end else if (en) begin
      v0_r <= in_valid;
      v2_r <= v1_r[L-1];
      vo_r <= v3_r[L-1];
      for (int i = 0; i < L; i++) begin
        v1_r[i] <= (i == 0) ? v0_r : v1_r[(i == 0) ? 0 : i-1];
        v3_r[i] <= (i == 0) ? v2_r : v3_r[(i == 0) ? 0 : i-1];
      end
    end
  end

  assign out_valid = vo_r;
  assign out_rgb   = out_rgb_r;

  // the new minimum never drops below zero
  a_lo_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    v1_r[L-1] && !it1.pass && (it1.span != '0) |-> q_lo <= it1.hi)
    else $error("minimum quotient exceeds new maximum");

  // remapped channels stay inside [lo, hi]
  a_map_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    v3_r[L-1] && !wk3.item.pass && (wk3.item.span != '0) |->
      (sum_ch[0] <= {1'b0, wk3.item.hi}) && (sum_ch[1] <= {1'b0, wk3.item.hi}) &&
      (sum_ch[2] <= {1'b0, wk3.item.hi}))
    else $error("remapped channel above new maximum");

  // a stalled pipeline keeps its occupancy
  a_stall_freeze: assert property (@(posedge clk) disable iff (!rst_n)
    !en |=> $stable(v0_r) && $stable(v2_r) && $stable(v1_r[L-1]) && $stable(v3_r[L-1]))
    else $error("pipeline moved while stalled");

endmodule
